/* rtl/core/knn_pkg.sv */
// ----------------------------------------------------------------------------
// knn_pkg
// Shared types and constants for the brute-force nearest neighbor search.
// ----------------------------------------------------------------------------
package knn_pkg;

    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_MAX_DIMS   = 16;
    localparam int DEF_MAX_K      = 16;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        REG_NUM_POINTS = 2'd0,
        REG_DIMS       = 2'd1,
        REG_NBR_COUNT  = 2'd2,
        REG_NONE       = 2'd3
    } t_reg_addr;

    typedef struct packed {
        logic               op;
        logic [9:0]         point_index;
        logic [3:0]         dim_index;
        logic signed [15:0] coord;
    } t_knn_in;

    typedef struct packed {
        logic [3:0]  rank;
        logic [9:0]  neighbor_index;
        logic [17:0] neighbor_distance;
        logic        last;
    } t_knn_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_SQRT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic init;
        logic step;
        logic sqrt_start;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic trig;
        logic walk_last;
        logic pipe_idle;
        logic sqrt_done;
        logic last_rank;
    } t_status;

endpackage

/* rtl/core/knn_ctrl.sv */
// ----------------------------------------------------------------------------
// knn_ctrl
// Sequencer: corpus walk, pipeline drain, square root and result emission.
// ----------------------------------------------------------------------------
module knn_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  knn_pkg::t_status i_status,
    output knn_pkg::t_cmd   o_cmd,
    output logic            o_busy
);

    knn_pkg::t_state r_state;
    knn_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= knn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            knn_pkg::ST_IDLE: begin
                if (i_start && i_status.trig) n_state = knn_pkg::ST_WALK;
            end
            knn_pkg::ST_WALK: begin
                if (i_status.walk_last) n_state = knn_pkg::ST_DRAIN;
            end
            knn_pkg::ST_DRAIN: begin
                if (i_status.pipe_idle) n_state = knn_pkg::ST_SQRT;
            end
            knn_pkg::ST_SQRT: begin
                if (i_status.sqrt_done) n_state = knn_pkg::ST_EMIT;
            end
            knn_pkg::ST_EMIT: begin
                n_state = i_status.last_rank ? knn_pkg::ST_IDLE : knn_pkg::ST_SQRT;
            end
            default: n_state = knn_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy            = (r_state != knn_pkg::ST_IDLE);
        o_cmd.accept      = (r_state == knn_pkg::ST_IDLE) && i_start;
        o_cmd.init        = o_cmd.accept && i_status.trig;
        o_cmd.step        = (r_state == knn_pkg::ST_WALK);
        o_cmd.sqrt_start  = ((r_state == knn_pkg::ST_DRAIN) && i_status.pipe_idle) ||
                            ((r_state == knn_pkg::ST_EMIT) && !i_status.last_rank);
        o_cmd.emit        = (r_state == knn_pkg::ST_SQRT) && i_status.sqrt_done;
    end

endmodule

/* rtl/core/knn_dp.sv */
// ----------------------------------------------------------------------------
// knn_dp
// Point store, distance pipeline, sorted best list and bit-pair square root.
// ----------------------------------------------------------------------------
module knn_dp #(
    parameter int MAX_POINTS = knn_pkg::DEF_MAX_POINTS,
    parameter int MAX_DIMS   = knn_pkg::DEF_MAX_DIMS,
    parameter int MAX_K      = knn_pkg::DEF_MAX_K,
    localparam int NPW = $clog2(MAX_POINTS + 1),
    localparam int NDW = $clog2(MAX_DIMS + 1),
    localparam int KCW = $clog2(MAX_K + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  knn_pkg::t_knn_in  i_item,
    input  logic [NPW-1:0]    i_np,
    input  logic [NDW-1:0]    i_nd,
    input  logic [KCW-1:0]    i_kk,
    input  knn_pkg::t_cmd     i_cmd,
    output knn_pkg::t_status  o_status,
    output logic              o_strobe,
    output knn_pkg::t_knn_out o_result
);

    localparam int PIW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int DIW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int KIW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int DEPTH = MAX_POINTS * MAX_DIMS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = 34 + ((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 0);
    localparam int SQW   = SW + (SW % 2);
    localparam int RW    = SQW / 2;
    localparam int SCW   = $clog2(RW + 1);

    logic [15:0]    r_mem [DEPTH];
    logic [15:0]    r_qbuf [MAX_DIMS];
    logic [15:0]    r_rd;

    logic [PIW-1:0] r_p;
    logic [DIW-1:0] r_j;

    logic           r_s1_vld, r_s1_first, r_s1_last;
    logic [DIW-1:0] r_s1_j;
    logic [PIW-1:0] r_s1_p;
    logic           r_s2_vld, r_s2_first, r_s2_last;
    logic [PIW-1:0] r_s2_p;
    logic [33:0]    r_s2_sq;
    logic [SW-1:0]  r_acc;
    logic           r_s3_vld;
    logic [PIW-1:0] r_s3_p;

    logic [SW-1:0]  r_best_d [MAX_K];
    logic [PIW-1:0] r_best_i [MAX_K];
    logic [KCW-1:0] r_count;
    logic [KIW-1:0] r_rank;

    logic [SQW-1:0] r_sq_val;
    logic [RW+1:0]  r_rem;
    logic [RW-1:0]  r_root;
    logic [SCW-1:0] r_sq_cnt;
    logic           r_sq_run;

    logic           r_out_vld;
    knn_pkg::t_knn_out r_out;

    logic           w_load_ok;
    logic           w_query_ok;
    logic [AW-1:0]  w_wr_addr;
    logic [AW-1:0]  w_rd_addr;
    logic           w_j_last;
    logic signed [16:0] w_diff;
    logic signed [33:0] w_sq;
    logic [MAX_K-1:0] w_lt;
    logic           w_ins;
    logic [RW+1:0]  w_rem_sh;
    logic [RW+1:0]  w_trial;

    always_comb begin
        w_load_ok  = (i_item.op == knn_pkg::OP_LOAD) &&
                     (32'(i_item.point_index) < MAX_POINTS) &&
                     (32'(i_item.dim_index) < MAX_DIMS);
        w_query_ok = (i_item.op == knn_pkg::OP_QUERY) && (32'(i_item.dim_index) < MAX_DIMS);
        w_wr_addr  = AW'(32'(i_item.point_index) * MAX_DIMS + 32'(i_item.dim_index));
        w_rd_addr  = AW'(32'(r_p) * MAX_DIMS + 32'(r_j));
        w_j_last   = (32'(r_j) == 32'(i_nd) - 1);
        o_status.trig      = w_query_ok && (32'(i_item.dim_index) == 32'(i_nd) - 1);
        o_status.walk_last = w_j_last && (32'(r_p) == 32'(i_np) - 1);
        o_status.pipe_idle = !(r_s1_vld || r_s2_vld || r_s3_vld);
        o_status.sqrt_done = !r_sq_run;
        o_status.last_rank = r_out.last;
    end

    // point store and query buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_load_ok) begin
            r_mem[w_wr_addr] <= i_item.coord;
        end
        if (i_cmd.step) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_query_ok) begin
            r_qbuf[DIW'(i_item.dim_index)] <= i_item.coord;
        end
    end

    // walk counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= '0;
            r_j <= '0;
        end else if (i_cmd.init) begin
            r_p <= '0;
            r_j <= '0;
        end else if (i_cmd.step) begin
            if (w_j_last) begin
                r_j <= '0;
                r_p <= r_p + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    // distance pipeline
    assign w_diff = $signed({r_qbuf[r_s1_j][15], r_qbuf[r_s1_j]}) - $signed({r_rd[15], r_rd});
    assign w_sq   = w_diff * w_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.step;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld && r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_j     <= r_j;
        r_s1_p     <= r_p;
        r_s1_first <= (r_j == '0);
        r_s1_last  <= w_j_last;
        r_s2_sq    <= $unsigned(w_sq);
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_p     <= r_s1_p;
        r_s3_p     <= r_s2_p;
        if (r_s2_vld) begin
            r_acc <= r_s2_first ? SW'(r_s2_sq) : r_acc + SW'(r_s2_sq);
        end
    end

    // sorted insertion, ties keep the lower index ahead
    always_comb begin
        for (int i = 0; i < MAX_K; i++) begin
            w_lt[i] = (32'(i) >= 32'(r_count)) || (r_acc < r_best_d[i]);
        end
        w_ins = 1'b0;
        for (int i = 0; i < MAX_K; i++) begin
            if (32'(i) < 32'(i_kk) && w_lt[i]) w_ins = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_vld) begin
            for (int i = 0; i < MAX_K; i++) begin
                if (32'(i) < 32'(i_kk) && w_lt[i]) begin
                    if (i == 0) begin
                        r_best_d[i] <= r_acc;
                        r_best_i[i] <= r_s3_p;
                    end else if (!w_lt[i-1]) begin
                        r_best_d[i] <= r_acc;
                        r_best_i[i] <= r_s3_p;
                    end else begin
                        r_best_d[i] <= r_best_d[i-1];
                        r_best_i[i] <= r_best_i[i-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rank  <= '0;
        end else begin
            if (i_cmd.init) begin
                r_count <= '0;
                r_rank  <= '0;
            end else begin
                if (r_s3_vld && w_ins && r_count < i_kk) r_count <= r_count + 1'b1;
                if (i_cmd.emit) r_rank <= r_rank + 1'b1;
            end
        end
    end

    // bit-pair square root, one result bit per cycle
    assign w_rem_sh = {r_rem[RW-1:0], r_sq_val[SQW-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_run <= 1'b0;
            r_sq_cnt <= '0;
        end else if (i_cmd.sqrt_start) begin
            r_sq_run <= 1'b1;
            r_sq_cnt <= SCW'(RW);
        end else if (r_sq_run) begin
            r_sq_cnt <= r_sq_cnt - 1'b1;
            if (r_sq_cnt == SCW'(1)) r_sq_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_sq_val <= SQW'(r_best_d[r_rank]);
            r_rem    <= '0;
            r_root   <= '0;
        end else if (r_sq_run) begin
            r_sq_val <= r_sq_val << 2;
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_out     <= '0;
        end else begin
            r_out_vld <= i_cmd.emit;
            if (i_cmd.emit) begin
                r_out.rank              <= 4'(r_rank);
                r_out.neighbor_index    <= 10'(r_best_i[r_rank]);
                r_out.neighbor_distance <= 18'(r_root);
                r_out.last              <= (KCW'(r_rank) + 1'b1 == r_count);
            end
        end
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

endmodule

/* rtl/core/brute_force_knn_search.sv */
// ----------------------------------------------------------------------------
// brute_force_knn_search
// k nearest neighbors by squared euclidean distance over a loaded point store.
// ----------------------------------------------------------------------------
// loads and non-final query coordinates are taken while idle, busy stays low
// final query coordinate: walk over num_points*dims store entries, one read each,
// then a pipeline drain, then per neighbor an RW-bit square root, RW = 19 by default
// results leave one per strobe and cannot be stalled
// synchronous active-low reset returns the setting registers to 1 and the sequencer to idle
module brute_force_knn_search #(
    parameter int MAX_POINTS = knn_pkg::DEF_MAX_POINTS,
    parameter int MAX_DIMS   = knn_pkg::DEF_MAX_DIMS,
    parameter int MAX_K      = knn_pkg::DEF_MAX_K
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  knn_pkg::t_knn_in             i_item,
    output logic                         o_strobe,
    output knn_pkg::t_knn_out            o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [knn_pkg::PADDR_W-1:0]  paddr,
    input  logic [knn_pkg::PDATA_W-1:0]  pwdata,
    output logic [knn_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int NPW = $clog2(MAX_POINTS + 1);
    localparam int NDW = $clog2(MAX_DIMS + 1);
    localparam int KCW = $clog2(MAX_K + 1);

    logic [10:0] r_num_points;
    logic [4:0]  r_dims;
    logic [4:0]  r_nbr_count;

    logic [NPW-1:0] w_np;
    logic [NDW-1:0] w_nd;
    logic [KCW-1:0] w_kk;
    logic           w_wr;
    knn_pkg::t_reg_addr w_addr;
    knn_pkg::t_cmd      w_cmd;
    knn_pkg::t_status   w_status;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_addr = knn_pkg::t_reg_addr'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= 11'd1;
            r_dims       <= 5'd1;
            r_nbr_count  <= 5'd1;
        end else if (w_wr) begin
            unique case (w_addr)
                knn_pkg::REG_NUM_POINTS: r_num_points <= pwdata[10:0];
                knn_pkg::REG_DIMS:       r_dims       <= pwdata[4:0];
                knn_pkg::REG_NBR_COUNT:  r_nbr_count  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_addr)
            knn_pkg::REG_NUM_POINTS: prdata = 32'(r_num_points);
            knn_pkg::REG_DIMS:       prdata = 32'(r_dims);
            knn_pkg::REG_NBR_COUNT:  prdata = 32'(r_nbr_count);
            default:                 prdata = '0;
        endcase
    end

    // effective settings after clamping
    always_comb begin
        if (r_num_points == '0) w_np = NPW'(1);
        else if (32'(r_num_points) > MAX_POINTS) w_np = NPW'(MAX_POINTS);
        else w_np = NPW'(r_num_points);

        if (r_dims == '0) w_nd = NDW'(1);
        else if (32'(r_dims) > MAX_DIMS) w_nd = NDW'(MAX_DIMS);
        else w_nd = NDW'(r_dims);

        if (r_nbr_count == '0) w_kk = KCW'(1);
        else if (32'(r_nbr_count) > MAX_K) w_kk = KCW'(MAX_K);
        else w_kk = KCW'(r_nbr_count);
        if (32'(w_kk) > 32'(w_np)) w_kk = KCW'(w_np);
    end

    knn_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (o_busy)
    );

    knn_dp #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIMS   (MAX_DIMS),
        .MAX_K      (MAX_K)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_np     (w_np),
        .i_nd     (w_nd),
        .i_kk     (w_kk),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

/* rtl/core/knn_chk.sv */
// ----------------------------------------------------------------------------
// knn_chk
// Port-level checks for the nearest neighbor search, bound to the top level.
// ----------------------------------------------------------------------------
module knn_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_start,
    input logic                        o_busy,
    input logic                        o_strobe,
    input knn_pkg::t_knn_out           o_result,
    input logic                        pready
);

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_busy)
        else $error("result transaction outside a search");

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |=> o_busy)
        else $error("search ended before last transaction");

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("back to back result transactions");

    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("busy without a start");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind brute_force_knn_search knn_chk u_knn_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_result (o_result),
    .pready   (pready)
);

/* tb/knn_checker.sv */
// ----------------------------------------------------------------------------
// knn_checker
// Watches the item, result and register ports of the nearest neighbor search,
// keeps its own copy of the point store and registers, predicts the ranked
// neighbors of every completed query and compares each result transaction.
// ----------------------------------------------------------------------------
module knn_checker
    import knn_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_knn_in              i_item,
    input  logic                 i_strobe,
    input  t_knn_out             i_result,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic                 i_pready,
    input  logic [PADDR_W-1:0]   i_paddr,
    input  logic [PDATA_W-1:0]   i_pwdata,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic signed [15:0] point_mem [0:DEF_MAX_POINTS*DEF_MAX_DIMS-1];
    logic signed [15:0] query_mem [0:DEF_MAX_DIMS-1];
    logic [10:0]        cfg_points;
    logic [4:0]         cfg_dims;
    logic [4:0]         cfg_k;
    t_knn_out           neighbor_q [$];

    assign o_pending = neighbor_q.size();

    function automatic logic [17:0] floor_sqrt(input logic [35:0] v);
        logic [17:0] r;
        logic [17:0] t;
        r = '0;
        for (int b = 17; b >= 0; b--) begin
            t = r | (18'd1 << b);
            if ({18'd0, t} * {18'd0, t} <= {28'd0, v}) r = t;
        end
        return r;
    endfunction

    task automatic predict_neighbors();
        int          np;
        int          nd;
        int          kk;
        int          cnt;
        int          pos;
        logic [35:0] sum;
        logic signed [16:0] diff;
        logic signed [33:0] sq;
        logic [35:0] best_d [DEF_MAX_K];
        int          best_i [DEF_MAX_K];
        t_knn_out    res;
        np = (cfg_points == 0) ? 1 : (cfg_points > DEF_MAX_POINTS) ? DEF_MAX_POINTS
                                                                  : int'(cfg_points);
        nd = (cfg_dims == 0) ? 1 : (cfg_dims > DEF_MAX_DIMS) ? DEF_MAX_DIMS : int'(cfg_dims);
        kk = (cfg_k == 0) ? 1 : (cfg_k > DEF_MAX_K) ? DEF_MAX_K : int'(cfg_k);
        if (kk > np) kk = np;
        cnt = 0;
        for (int p = 0; p < np; p++) begin
            sum = '0;
            for (int j = 0; j < nd; j++) begin
                diff = 17'(query_mem[j]) - 17'(point_mem[p*DEF_MAX_DIMS + j]);
                sq   = diff * diff;
                sum += 36'($unsigned(sq));
            end
            pos = cnt;
            while (pos > 0 && sum < best_d[pos-1]) pos--;
            if (pos < kk) begin
                if (cnt < kk) cnt++;
                for (int r = cnt - 1; r > pos; r--) begin
                    best_d[r] = best_d[r-1];
                    best_i[r] = best_i[r-1];
                end
                best_d[pos] = sum;
                best_i[pos] = p;
            end
        end
        for (int r = 0; r < cnt; r++) begin
            res.rank              = 4'(r);
            res.neighbor_index    = 10'(best_i[r]);
            res.neighbor_distance = floor_sqrt(best_d[r]);
            res.last              = (r == cnt - 1);
            neighbor_q.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin
        t_knn_out exp_res;
        int       errs;
        errs = 0;
        if (!i_rst_n) begin
            cfg_points   = 11'd1;
            cfg_dims     = 5'd1;
            cfg_k        = 5'd1;
            o_fail_count <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_addr'(i_paddr[3:2]))
                    REG_NUM_POINTS: cfg_points = i_pwdata[10:0];
                    REG_DIMS:       cfg_dims   = i_pwdata[4:0];
                    REG_NBR_COUNT:  cfg_k      = i_pwdata[4:0];
                    default: ;
                endcase
            end
            if (i_strobe) begin
                if (neighbor_q.size() == 0) begin
                    $error("unexpected result transaction: %p", i_result);
                    errs++;
                end else begin
                    exp_res = neighbor_q.pop_front();
                    if (i_result.rank !== exp_res.rank) begin
                        $error("rank: expected %0d, actual %0d", exp_res.rank, i_result.rank);
                        errs++;
                    end
                    if (i_result.neighbor_index !== exp_res.neighbor_index) begin
                        $error("neighbor_index: expected %0d, actual %0d",
                               exp_res.neighbor_index, i_result.neighbor_index);
                        errs++;
                    end
                    if (i_result.neighbor_distance !== exp_res.neighbor_distance) begin
                        $error("neighbor_distance: expected %0d, actual %0d",
                               exp_res.neighbor_distance, i_result.neighbor_distance);
                        errs++;
                    end
                    if (i_result.last !== exp_res.last) begin
                        $error("last: expected %0d, actual %0d", exp_res.last, i_result.last);
                        errs++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_item.op == OP_LOAD) begin
                    point_mem[i_item.point_index*DEF_MAX_DIMS + i_item.dim_index] = i_item.coord;
                end else begin
                    query_mem[i_item.dim_index] = i_item.coord;
                    if (int'(i_item.dim_index) ==
                        ((cfg_dims == 0) ? 0 : (cfg_dims > DEF_MAX_DIMS) ? DEF_MAX_DIMS - 1
                                                                         : cfg_dims - 1))
                        predict_neighbors();
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives corpus loads, query coordinates and register writes into the nearest
// neighbor search: directed extremes first, then random phases of settings,
// point sets and queries with random gaps; the checker judges every result.
// ----------------------------------------------------------------------------
module testbench;
    import knn_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    t_knn_in            i_item;
    logic               o_strobe;
    t_knn_out           o_result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    int                 n_items;
    int                 stall_cycles;
    bit                 extreme_mode;
    bit                 no_gaps;
    bit                 q_written [DEF_MAX_DIMS];

    brute_force_knn_search u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    knn_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_item       (i_item),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_strobe || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [15:0] pick_coord();
        if (extreme_mode) return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2, 3:    return 16'($urandom_range(0, 4)) - 16'd2;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic op, input int pidx, input int didx,
                             input logic [15:0] c);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_item  = '{op: op, point_index: 10'(pidx), dim_index: 4'(didx), coord: c};
        i_start = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        @(negedge i_clk);
        n_items++;
    endtask

    task automatic wait_idle();
        i_start = 1'b0;
        while (pending != 0 || o_busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic reg_write(input t_reg_addr idx, input int value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'({idx, 2'b00});
        pwdata  = PDATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic run_query(input int nd);
        for (int j = 0; j < nd - 1; j++) begin
            if (!q_written[j] || $urandom_range(0, 3) != 0) begin
                send_item(OP_QUERY, $urandom_range(0, 1023), j, pick_coord());
                q_written[j] = 1'b1;
            end
        end
        if (nd < DEF_MAX_DIMS && $urandom_range(0, 4) == 0)
            send_item(OP_QUERY, $urandom_range(0, 1023), $urandom_range(nd, 15), pick_coord());
        send_item(OP_QUERY, $urandom_range(0, 1023), nd - 1, pick_coord());
        q_written[nd-1] = 1'b1;
    endtask

    task automatic run_phase(input int np_w, input int nd_w, input int k_w, input int nq);
        int np;
        int nd;
        wait_idle();
        reg_write(REG_NUM_POINTS, np_w);
        reg_write(REG_DIMS, nd_w);
        reg_write(REG_NBR_COUNT, k_w);
        np = (np_w == 0) ? 1 : (np_w > DEF_MAX_POINTS) ? DEF_MAX_POINTS : np_w;
        nd = (nd_w == 0) ? 1 : (nd_w > DEF_MAX_DIMS) ? DEF_MAX_DIMS : nd_w;
        for (int p = 0; p < np; p++)
            for (int d = 0; d < nd; d++)
                send_item(OP_LOAD, p, d, pick_coord());
        for (int q = 0; q < nq; q++) begin
            repeat ($urandom_range(0, 2))
                send_item(OP_LOAD, $urandom_range(0, np - 1), $urandom_range(0, 15),
                          pick_coord());
            run_query(nd);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_item       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        n_items      = 0;
        extreme_mode = 1'b1;
        no_gaps      = 1'b0;
        q_written    = '{default: 1'b0};
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes: max distance, clamped neighbor count, out of range settings
        run_phase(2, 16, 16, 2);
        extreme_mode = 1'b0;
        wait_idle();
        reg_write(REG_NONE, 5);
        run_phase(0, 0, 0, 2);
        run_phase(2, 31, 31, 2);
        no_gaps = 1'b1;
        run_phase(2, 1, 16, 2);

        while (n_items < 470) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            run_phase($urandom_range(1, 12), $urandom_range(1, 16), $urandom_range(0, 20),
                      $urandom_range(3, 8));
        end

        wait_idle();
        repeat (40) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/knn_pkg.sv
rtl/core/knn_ctrl.sv
rtl/core/knn_dp.sv
rtl/core/brute_force_knn_search.sv
rtl/core/knn_chk.sv
tb/knn_checker.sv
tb/testbench.sv
